FILE: rtl/sssl_pkg.sv
// Package with the shared types, constants and functions of the seven-segment score line generator.
package sssl_pkg;

   localparam int DigitCount = 5;
   localparam int DigitIndexWidth = $clog2(DigitCount);
   localparam logic [DigitIndexWidth-1:0] LastDigit = DigitIndexWidth'(DigitCount - 1);

   localparam logic [7:0] DigitWidthPx = 8'd4;
   localparam logic [7:0] DigitHeightPx = 8'd6;
   localparam logic [7:0] DigitHalfPx = 8'd3;
   localparam logic [7:0] DigitPitchPx = 8'd6;

   typedef struct packed {
      logic [15:0] value;
      logic [7:0]  origin_x;
      logic [7:0]  origin_y;
   } req_type;

   typedef struct packed {
      logic [7:0] start_x;
      logic [7:0] start_y;
      logic [7:0] end_x;
      logic [7:0] end_y;
      logic       last_line;
   } rsp_type;

   typedef enum logic [2:0] {
      SEG_G = 3'd0,
      SEG_F = 3'd1,
      SEG_E = 3'd2,
      SEG_D = 3'd3,
      SEG_C = 3'd4,
      SEG_B = 3'd5,
      SEG_A = 3'd6
   } seg_type;

   // Segment pattern of a decimal digit, bit 6 is segment A and bit 0 is segment G.
   function automatic logic [6:0] seg_pattern(logic [3:0] digit);
      logic [6:0] pattern;
      unique case (digit)
         4'd0: pattern = 7'h7E;
         4'd1: pattern = 7'h30;
         4'd2: pattern = 7'h6D;
         4'd3: pattern = 7'h79;
         4'd4: pattern = 7'h33;
         4'd5: pattern = 7'h5B;
         4'd6: pattern = 7'h5F;
         4'd7: pattern = 7'h70;
         4'd8: pattern = 7'h7F;
         default: pattern = 7'h7B;
      endcase
      return pattern;
   endfunction

   // Decimal weight of digit position k, most significant position first.
   function automatic logic [16:0] dec_weight(logic [DigitIndexWidth-1:0] k);
      logic [16:0] weight;
      unique case (k)
         3'd0: weight = 17'd10000;
         3'd1: weight = 17'd1000;
         3'd2: weight = 17'd100;
         3'd3: weight = 17'd10;
         default: weight = 17'd1;
      endcase
      return weight;
   endfunction

   // Decimal digit of rest at position k; rest is below ten times the weight.
   function automatic logic [3:0] dec_digit(logic [15:0] rest, logic [DigitIndexWidth-1:0] k);
      logic [3:0]  digit;
      logic [16:0] weight;
      weight = dec_weight(k);
      digit = 4'd0;
      for (int j = 1; j <= 9; j++) begin
         if ({1'b0, rest} >= 17'(j) * weight) begin
            digit = 4'(j);
         end
      end
      return digit;
   endfunction

endpackage

FILE: rtl/seven_segment_score_line_generator_top.sv
// Top level of the seven-segment score line generator.
// Each accepted transaction carries a 16-bit value and an origin; the block shows the value as
// five decimal digits with leading zeros, 4 by 6 pixels each and 6 pixels apart, and sends one
// line transaction per lit segment in the order A to G, digit by digit from the left, with the
// last line of the value flagged. Coordinates wrap modulo 256. A value moves from the input
// register into the single line emitter, which then sends one line per lit segment as the
// output accepts them; the next value is held in the input register meanwhile. Reset is
// synchronous and clears the control state only.
module seven_segment_score_line_generator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sssl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sssl_pkg::rsp_type rsp_data
);
   import sssl_pkg::*;

   logic                       pend_valid_ff, pend_valid_in;
   req_type                    pend_ff, pend_in;
   logic                       active_ff, active_in;
   logic [15:0]                rest_ff, rest_in;
   logic [6:0]                 mask_ff, mask_in;
   logic [DigitIndexWidth-1:0] digit_idx_ff, digit_idx_in;
   logic [7:0]                 x_ff, x_in;
   logic [7:0]                 y_ff, y_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   logic                       req_accept;
   logic                       load;
   logic                       advance;
   logic                       emit;
   logic [15:0]                conv_rest;
   logic [DigitIndexWidth-1:0] conv_idx;
   logic [3:0]                 conv_digit;
   logic [15:0]                conv_rest_next;
   logic [6:0]                 conv_mask;
   seg_type                    seg_sel;
   logic [6:0]                 mask_left;
   logic                       digit_done;
   logic                       value_done;
   rsp_type                    line;

   assign req_ready  = !pend_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign load       = !active_ff && pend_valid_ff;
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign emit       = active_ff && advance;

   // One decimal digit is extracted per digit step, either from a new value or from the rest.
   assign conv_rest      = load ? pend_ff.value : rest_ff;
   assign conv_idx       = load ? '0 : digit_idx_ff + 1'b1;
   assign conv_digit     = dec_digit(conv_rest, conv_idx);
   assign conv_rest_next = conv_rest - 16'(17'(conv_digit) * dec_weight(conv_idx));
   assign conv_mask      = seg_pattern(conv_digit);

   always_comb begin
      priority if (mask_ff[SEG_A]) seg_sel = SEG_A;
      else if (mask_ff[SEG_B])     seg_sel = SEG_B;
      else if (mask_ff[SEG_C])     seg_sel = SEG_C;
      else if (mask_ff[SEG_D])     seg_sel = SEG_D;
      else if (mask_ff[SEG_E])     seg_sel = SEG_E;
      else if (mask_ff[SEG_F])     seg_sel = SEG_F;
      else                         seg_sel = SEG_G;
   end

   assign mask_left  = mask_ff & ~(7'd1 << seg_sel);
   assign digit_done = (mask_left == '0);
   assign value_done = digit_done && (digit_idx_ff == LastDigit);

   always_comb begin
      line.last_line = value_done;
      unique case (seg_sel)
         SEG_A: begin
            line.start_x = x_ff;                line.start_y = y_ff;
            line.end_x   = x_ff + DigitWidthPx; line.end_y   = y_ff;
         end
         SEG_B: begin
            line.start_x = x_ff + DigitWidthPx; line.start_y = y_ff;
            line.end_x   = x_ff + DigitWidthPx; line.end_y   = y_ff + DigitHalfPx;
         end
         SEG_C: begin
            line.start_x = x_ff + DigitWidthPx; line.start_y = y_ff + DigitHalfPx;
            line.end_x   = x_ff + DigitWidthPx; line.end_y   = y_ff + DigitHeightPx;
         end
         SEG_D: begin
            line.start_x = x_ff;                line.start_y = y_ff + DigitHeightPx;
            line.end_x   = x_ff + DigitWidthPx; line.end_y   = y_ff + DigitHeightPx;
         end
         SEG_E: begin
            line.start_x = x_ff;                line.start_y = y_ff + DigitHalfPx;
            line.end_x   = x_ff;                line.end_y   = y_ff + DigitHeightPx;
         end
         SEG_F: begin
            line.start_x = x_ff;                line.start_y = y_ff;
            line.end_x   = x_ff;                line.end_y   = y_ff + DigitHalfPx;
         end
         default: begin
            line.start_x = x_ff;                line.start_y = y_ff + DigitHalfPx;
            line.end_x   = x_ff + DigitWidthPx; line.end_y   = y_ff + DigitHalfPx;
         end
      endcase
   end

   always_comb begin
      pend_valid_in = req_accept || (pend_valid_ff && !load);
      pend_in       = req_accept ? req_data : pend_ff;

      active_in    = active_ff;
      rest_in      = rest_ff;
      mask_in      = mask_ff;
      digit_idx_in = digit_idx_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      if (load) begin
         active_in    = 1'b1;
         rest_in      = conv_rest_next;
         mask_in      = conv_mask;
         digit_idx_in = '0;
         x_in         = pend_ff.origin_x;
         y_in         = pend_ff.origin_y;
      end else if (emit) begin
         if (value_done) begin
            active_in = 1'b0;
            mask_in   = mask_left;
         end else if (digit_done) begin
            rest_in      = conv_rest_next;
            mask_in      = conv_mask;
            digit_idx_in = conv_idx;
            x_in         = x_ff + DigitPitchPx;
         end else begin
            mask_in = mask_left;
         end
      end

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
      rsp_in       = emit ? line : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff      <= pend_in;
      rest_ff      <= rest_in;
      mask_ff      <= mask_in;
      digit_idx_ff <= digit_idx_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A value in progress always has a segment left to send.
   a_active_mask : assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (mask_ff != '0))
      else $error("Active value has no segment left.");

   a_digit_range : assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (digit_idx_ff <= LastDigit))
      else $error("Digit position out of range.");

   a_start_first : assert property (@(posedge clock) disable iff (reset)
      $rose(active_ff) |-> (digit_idx_ff == '0))
      else $error("Value did not start at the first digit.");

   // Sending the flagged line ends the value.
   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      (emit && value_done) |=> (!active_ff && rsp_valid_ff && rsp_ff.last_line))
      else $error("Last line did not end the value.");

endmodule
